/* src/tsc_pkg.sv */
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, widths, constants and the microcode program of the Taylor
// series sine/cosine sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

    localparam int FRAC_BITS = 30;
    localparam int ANGLE_W   = 32;
    localparam int THR_W     = 31;
    localparam int VALUE_W   = 32;
    localparam int CNT_W     = 5;

    // term magnitudes stay below 8.0, squared angle below 16.0
    localparam int MAG_W     = 33;
    localparam int A2_W      = 34;
    localparam int HALF_W    = 17;
    localparam int PROD_W    = MAG_W + HALF_W;
    localparam int ACC_W     = MAG_W + A2_W;
    localparam int SUM_W     = 36;

    // divider: dividend width, quotient bits per step
    localparam int DIV_W      = 36;
    localparam int DIV_DIGITS = 4;
    localparam int DIV_STEPS  = DIV_W / DIV_DIGITS;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam logic [ANGLE_W-1:0] PI_FX         = 32'hC90F_DAA2;
    localparam logic [THR_W-1:0]   THR_RESET     = 31'd1074;
    localparam logic [MAG_W-1:0]   MAG_ONE       = MAG_W'(64'd1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] SUM_POS_ONE = SUM_W'(64'd1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] SUM_NEG_ONE = -SUM_POS_ONE;
    localparam logic signed [VALUE_W-1:0] VALUE_ONE = VALUE_W'(64'd1 << FRAC_BITS);

    typedef logic [3:0] t_step;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_SET_A2,
        OP_INIT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ACCUM,
        OP_STORE
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_WAIT_START,
        C_DIV_MORE,
        C_MORE,
        C_ODD
    } t_cond;

    typedef enum logic {
        SRC_SQUARE,
        SRC_TERM
    } t_msrc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_msrc src;
        t_step target;
    } t_uword;

    localparam t_step S_WAIT     = 4'd0;
    localparam t_step S_SQ_LO    = 4'd1;
    localparam t_step S_SQ_HI    = 4'd2;
    localparam t_step S_SET_A2   = 4'd3;
    localparam t_step S_INIT     = 4'd4;
    localparam t_step S_TERM_LO  = 4'd5;
    localparam t_step S_TERM_HI  = 4'd6;
    localparam t_step S_DIV_INIT = 4'd7;
    localparam t_step S_DIV_STEP = 4'd8;
    localparam t_step S_ACCUM    = 4'd9;
    localparam t_step S_TEST     = 4'd10;
    localparam t_step S_STORE    = 4'd11;
    localparam t_step S_RETURN   = 4'd12;

    function automatic t_uword ucode(input t_step step);
        t_uword uw;
        uw = '{op: OP_NOP, cond: C_JUMP, src: SRC_SQUARE, target: S_WAIT};
        unique case (step)
            S_WAIT:     uw = '{OP_ACCEPT,   C_WAIT_START, SRC_SQUARE, S_WAIT};
            S_SQ_LO:    uw = '{OP_MUL_LO,   C_NEXT,       SRC_SQUARE, S_WAIT};
            S_SQ_HI:    uw = '{OP_MUL_HI,   C_NEXT,       SRC_SQUARE, S_WAIT};
            S_SET_A2:   uw = '{OP_SET_A2,   C_NEXT,       SRC_SQUARE, S_WAIT};
            S_INIT:     uw = '{OP_INIT,     C_NEXT,       SRC_TERM,   S_WAIT};
            S_TERM_LO:  uw = '{OP_MUL_LO,   C_NEXT,       SRC_TERM,   S_WAIT};
            S_TERM_HI:  uw = '{OP_MUL_HI,   C_NEXT,       SRC_TERM,   S_WAIT};
            S_DIV_INIT: uw = '{OP_DIV_INIT, C_NEXT,       SRC_TERM,   S_WAIT};
            S_DIV_STEP: uw = '{OP_DIV_STEP, C_DIV_MORE,   SRC_TERM,   S_DIV_STEP};
            S_ACCUM:    uw = '{OP_ACCUM,    C_NEXT,       SRC_TERM,   S_WAIT};
            S_TEST:     uw = '{OP_NOP,      C_MORE,       SRC_TERM,   S_TERM_LO};
            S_STORE:    uw = '{OP_STORE,    C_ODD,        SRC_TERM,   S_INIT};
            S_RETURN:   uw = '{OP_NOP,      C_JUMP,       SRC_TERM,   S_WAIT};
            default:    uw = '{OP_NOP,      C_JUMP,       SRC_SQUARE, S_WAIT};
        endcase
        return uw;
    endfunction

    // clamp a wide sum to +-1.0 and keep the low word
    function automatic logic [VALUE_W-1:0] sat_value(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] c;
        c = s;
        if (s > SUM_POS_ONE) begin
            c = SUM_POS_ONE;
        end else if (s < SUM_NEG_ONE) begin
            c = SUM_NEG_ONE;
        end
        return c[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/taylor_sine_cosine.sv */
// ----------------------------------------------------------------------------
// taylor_sine_cosine
// Sine and cosine of one angle by Taylor series, run by a microcoded
// sequencer over a shared 33x17 multiplier and a 4-bit-per-cycle divider.
// ----------------------------------------------------------------------------
// Takes an unsigned Q2.30 angle (clamped to pi) when start is high and busy is
// low, and returns signed Q2.30 sine and cosine, the term counts and a
// converged flag as a one-cycle o_valid pulse that cannot be held off. Each
// series term takes two multiplier passes, nine divider steps and
// bookkeeping, and the next angle can be taken in the cycle after o_valid.
// Both series share one multiplier and one divider, and run one after the
// other.
`default_nettype none

module taylor_sine_cosine #(
    parameter int MAX_TERMS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tsc_pkg::THR_W-1:0]          i_cfg_wdata,
    input  wire logic                               start,
    input  wire logic [tsc_pkg::ANGLE_W-1:0]        i_angle,
    output logic                                    busy,
    output logic                                    o_valid,
    output logic signed [tsc_pkg::VALUE_W-1:0]      o_sine_value,
    output logic signed [tsc_pkg::VALUE_W-1:0]      o_cosine_value,
    output logic [tsc_pkg::CNT_W-1:0]               o_sine_terms,
    output logic [tsc_pkg::CNT_W-1:0]               o_cosine_terms,
    output logic                                    o_converged
);
    import tsc_pkg::*;

    localparam int N_W    = $clog2(MAX_TERMS + 1);
    localparam int K_W    = $clog2(2 * MAX_TERMS + 3);
    localparam int PAIR_W = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);

    logic [THR_W-1:0]        r_thr;
    t_step                   r_pc,  n_pc;
    logic [ANGLE_W-1:0]      r_a;
    logic [A2_W-1:0]         r_a2;
    logic [MAG_W-1:0]        r_mag;
    logic signed [SUM_W-1:0] r_sum;
    logic [ACC_W-1:0]        r_acc;
    logic [DIV_W-1:0]        r_quo, n_quo;
    logic [PAIR_W-1:0]       r_rem, n_rem;
    logic [PAIR_W-1:0]       r_pair;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [N_W-1:0]          r_n;
    logic                    r_odd;
    logic                    r_conv;
    logic [VALUE_W-1:0]      r_sin_val;
    logic [CNT_W-1:0]        r_sn;
    logic                    r_sconv;
    logic                    r_valid;
    logic [VALUE_W-1:0]      r_out_sin;
    logic [VALUE_W-1:0]      r_out_cos;
    logic [CNT_W-1:0]        r_out_sn;
    logic [CNT_W-1:0]        r_out_cn;
    logic                    r_out_conv;

    t_uword                  w_uw;
    logic                    w_taken;
    logic [MAG_W-1:0]        w_mul_a;
    logic [HALF_W-1:0]       w_mul_b;
    logic [PROD_W-1:0]       w_prod;
    logic [K_W-1:0]          w_k;
    logic [K_W-1:0]          w_kx;
    logic [PAIR_W-1:0]       w_pair;
    logic [MAG_W-1:0]        w_q;
    logic signed [SUM_W-1:0] w_q_ext;
    logic [CNT_W-1:0]        w_cnt;

    assign w_uw = ucode(r_pc);

    // sequencer
    always_comb begin
        unique case (w_uw.cond)
            C_NEXT:       w_taken = 1'b0;
            C_JUMP:       w_taken = 1'b1;
            C_WAIT_START: w_taken = !start;
            C_DIV_MORE:   w_taken = (r_dcnt != DCNT_W'(DIV_STEPS - 1));
            C_MORE:       w_taken = !r_conv && (r_n != N_W'(MAX_TERMS));
            C_ODD:        w_taken = r_odd;
            default:      w_taken = 1'b0;
        endcase
        n_pc = w_taken ? w_uw.target : r_pc + t_step'(1);
    end

    // shared multiplier, second operand split in 17-bit halves
    always_comb begin
        if (w_uw.src == SRC_SQUARE) begin
            w_mul_a = MAG_W'(r_a);
            w_mul_b = (w_uw.op == OP_MUL_HI) ? HALF_W'(r_a[ANGLE_W-1:HALF_W])
                                             : r_a[HALF_W-1:0];
        end else begin
            w_mul_a = r_mag;
            w_mul_b = (w_uw.op == OP_MUL_HI) ? r_a2[A2_W-1:HALF_W] : r_a2[HALF_W-1:0];
        end
        w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    end

    // factorial pair for the next term
    always_comb begin
        w_k    = K_W'({r_n, 1'b0}) + K_W'(2);
        w_kx   = r_odd ? w_k + K_W'(1) : w_k - K_W'(1);
        w_pair = PAIR_W'(w_k * w_kx);
    end

    // restoring divider, four quotient bits a step
    always_comb begin
        logic [PAIR_W:0] rem_t;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int j = 0; j < DIV_DIGITS; j++) begin
            rem_t = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (rem_t >= {1'b0, r_pair}) begin
                rem_t    = rem_t - {1'b0, r_pair};
                n_quo[0] = 1'b1;
            end
            n_rem = rem_t[PAIR_W-1:0];
        end
    end

    assign w_q     = r_quo[MAG_W-1:0];
    assign w_q_ext = SUM_W'(w_q);
    assign w_cnt   = CNT_W'(r_n) + CNT_W'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_pc    <= S_WAIT;
            r_valid <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (w_uw.op == OP_STORE && !r_odd) begin
                r_valid <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (w_uw.op)
            OP_NOP: begin
            end
            OP_ACCEPT: begin
                if (start) begin
                    r_a <= (i_angle > PI_FX) ? PI_FX : i_angle;
                end
            end
            OP_MUL_LO: begin
                r_acc  <= ACC_W'(w_prod);
                r_pair <= w_pair;
            end
            OP_MUL_HI: begin
                r_acc <= r_acc + {w_prod, {HALF_W{1'b0}}};
            end
            OP_SET_A2: begin
                r_a2  <= r_acc[FRAC_BITS +: A2_W];
                r_odd <= 1'b1;
            end
            OP_INIT: begin
                r_mag  <= r_odd ? MAG_W'(r_a) : MAG_ONE;
                r_sum  <= r_odd ? SUM_W'(r_a) : SUM_W'(MAG_ONE);
                r_n    <= '0;
                r_conv <= 1'b0;
            end
            OP_DIV_INIT: begin
                r_quo  <= r_acc[FRAC_BITS +: DIV_W];
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            OP_DIV_STEP: begin
                r_quo  <= n_quo;
                r_rem  <= n_rem;
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            OP_ACCUM: begin
                r_mag  <= w_q;
                r_sum  <= r_n[0] ? r_sum + w_q_ext : r_sum - w_q_ext;
                r_n    <= r_n + N_W'(1);
                r_conv <= (w_q < MAG_W'(r_thr));
            end
            OP_STORE: begin
                if (r_odd) begin
                    r_sin_val <= sat_value(r_sum);
                    r_sn      <= w_cnt;
                    r_sconv   <= r_conv;
                    r_odd     <= 1'b0;
                end else begin
                    r_out_sin  <= r_sin_val;
                    r_out_cos  <= sat_value(r_sum);
                    r_out_sn   <= r_sn;
                    r_out_cn   <= w_cnt;
                    r_out_conv <= r_sconv && r_conv;
                end
            end
            default: begin
            end
        endcase
    end

    assign busy           = (r_pc != S_WAIT);
    assign o_valid        = r_valid;
    assign o_sine_value   = r_out_sin;
    assign o_cosine_value = r_out_cos;
    assign o_sine_terms   = r_out_sn;
    assign o_cosine_terms = r_out_cn;
    assign o_converged    = r_out_conv;

endmodule

`default_nettype wire

/* src/tsc_checker.sv */
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks on the Taylor sine/cosine block, bound into its module.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                o_valid,
    input wire logic signed [tsc_pkg::VALUE_W-1:0]  o_sine_value,
    input wire logic signed [tsc_pkg::VALUE_W-1:0]  o_cosine_value
);
    import tsc_pkg::*;

    // result strobe lasts a single cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // a result only appears while a transfer is still in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // an accepted angle makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted but block not busy");

    // both outputs stay within +-1.0 while o_valid is high
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sine_value <= VALUE_ONE) && (o_sine_value >= -VALUE_ONE)
                 && (o_cosine_value <= VALUE_ONE) && (o_cosine_value >= -VALUE_ONE))
        else $error("result outside +-1.0");

endmodule

bind taylor_sine_cosine tsc_checker u_tsc_checker (.*);

`default_nettype wire
